// ===== hw/rtl/rmap_pkg.sv =====
// Package with the shared constants, types and CRC function of the RMAP target command engine.
package rmap_pkg;

  localparam int unsigned MemAddrBits = 16;
  localparam int unsigned MaxDataLen  = 32;
  localparam int unsigned BufAddrBits = (MaxDataLen > 1) ? $clog2(MaxDataLen) : 1;
  localparam int unsigned MemDepth    = 1 << MemAddrBits;

  localparam logic [7:0] ProtoId  = 8'h01;
  localparam int unsigned BitCmd   = 6;
  localparam int unsigned BitWrite = 5;
  localparam int unsigned BitReply = 3;
  localparam logic [7:0] HdrLast  = 8'd15;
  localparam logic [7:0] ZeroByte = 8'h00;

  localparam logic CfgKey    = 1'b0;
  localparam logic CfgEnable = 1'b1;

  typedef enum logic [1:0] {
    OutcomeOk     = 2'd0,
    OutcomeLength = 2'd1,
    OutcomeReject = 2'd2,
    OutcomeCrc    = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       byte_valid;
    logic [1:0] outcome;
    logic       run_last;
  } out_word_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 8'hE0) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rmap_stream_if.sv =====
// Interface for a valid/ready word channel.
interface rmap_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rmap_target_command_engine.sv =====
// Top level of the RMAP target command engine.
//
//   channel  direction  word
//   in_if    sink       packet_byte, packet_end
//   out_if   source     reply_byte, byte_valid, outcome, run_last
//   cfg      write      target_key (0), target_enable (1)
//
// Command bytes are taken one per cycle while no reply word waits. A packet shorter than
// 16 bytes loads its status word at its end mark; any other goes to the header checks
// first. A passing write then copies its L data bytes into target memory. A read sends its
// 12 header words one per cycle while out ready allows, then each data byte after its
// registered memory read, then the data CRC. Every reply word waits for out ready, and
// input is stalled from the end mark until the last word leaves. Reset is asynchronous;
// the memories are not cleared.
module rmap_target_command_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  rmap_stream_if.sink         in_if,
  rmap_stream_if.source       out_if,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  localparam logic [2:0] StRecv  = 3'd0;
  localparam logic [2:0] StWrite = 3'd1;
  localparam logic [2:0] StHdr   = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [7:0] key_q;
  logic       enable_q;
  logic [2:0] state_q, state_d;
  logic [7:0] count_q, count_d;
  logic [7:0] hcrc_q, hcrc_d;
  logic [7:0] dcrc_q, dcrc_d;
  logic       dgood_q, dgood_d;
  logic [5:0] idx_q, idx_d;
  logic [7:0] crc_q, crc_d;
  logic [rmap_pkg::MemAddrBits-1:0] addr_q, addr_d;
  logic       rd_ok_q, rd_ok_d;
  logic       ovalid_q, ovalid_d;
  rmap_pkg::out_word_t oword_q, oword_d;
  logic [7:0] hdr_q [16];
  logic [7:0] wbuf [rmap_pkg::MaxDataLen];
  logic [7:0] tmem [rmap_pkg::MemDepth];
  logic [7:0] rd_q, wb_q;

  rmap_pkg::in_word_t iw;
  logic       in_fire, out_free, reject;
  logic [23:0] dl;
  logic [7:0] ins;
  logic [7:0] d;
  logic [5:0] rep_len;
  logic [7:0] rep [11];

  assign iw       = in_if.data;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !ovalid_q || out_if.ready;
  assign in_if.ready = (state_q == StRecv) && out_free;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = oword_q;
  assign dl  = {hdr_q[12], hdr_q[13], hdr_q[14]};
  assign ins = hdr_q[2];
  assign d   = count_q - 8'd16;
  assign rep_len = ins[rmap_pkg::BitWrite] ? 6'd7 : 6'd11;
  assign reject = !enable_q || hdr_q[1] != rmap_pkg::ProtoId || hdr_q[3] != key_q
                  || !ins[rmap_pkg::BitCmd];

  always_comb begin
    rep[0]  = hdr_q[4];
    rep[1]  = rmap_pkg::ProtoId;
    rep[2]  = ins & ~(8'd1 << rmap_pkg::BitCmd);
    rep[3]  = rmap_pkg::ZeroByte;
    rep[4]  = hdr_q[0];
    rep[5]  = hdr_q[5];
    rep[6]  = hdr_q[6];
    rep[7]  = rmap_pkg::ZeroByte;
    rep[8]  = hdr_q[12];
    rep[9]  = hdr_q[13];
    rep[10] = hdr_q[14];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && count_q < 8'd16) begin
      hdr_q[count_q[3:0]] <= iw.packet_byte;
    end
    if (in_fire && count_q >= 8'd16 && d < 8'(rmap_pkg::MaxDataLen)) begin
      wbuf[d[rmap_pkg::BufAddrBits-1:0]] <= iw.packet_byte;
    end
    wb_q <= wbuf[idx_q[rmap_pkg::BufAddrBits-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StWrite && rd_ok_q) begin
      tmem[addr_q] <= wb_q;
    end
    rd_q <= tmem[addr_q];
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    hcrc_d   = hcrc_q;
    dcrc_d   = dcrc_q;
    dgood_d  = dgood_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    addr_d   = addr_q;
    rd_ok_d  = rd_ok_q;
    ovalid_d = ovalid_q && !out_if.ready;
    oword_d  = oword_q;
    case (state_q)
      StRecv: begin
        if (in_fire) begin
          if (count_q < 8'd15) hcrc_d = rmap_pkg::crc_step(hcrc_q, iw.packet_byte);
          if (count_q >= 8'd16) begin
            if (24'(d) < dl) dcrc_d = rmap_pkg::crc_step(dcrc_q, iw.packet_byte);
            else if (24'(d) == dl) dgood_d = (iw.packet_byte == dcrc_q);
          end
          if (count_q != 8'd255) count_d = count_q + 8'd1;
          if (iw.packet_end) begin
            if (count_q < rmap_pkg::HdrLast) begin
              oword_d = '{rmap_pkg::ZeroByte, 1'b0, rmap_pkg::OutcomeLength, 1'b1};
              ovalid_d = 1'b1;
              count_d = '0;
              hcrc_d = '0;
              dcrc_d = '0;
              dgood_d = 1'b0;
            end else begin
              state_d = StHdr;
            end
          end
        end
      end
      StHdr: begin
        if (out_free) begin
          oword_d = '{rmap_pkg::ZeroByte, 1'b0, rmap_pkg::OutcomeOk, 1'b1};
          ovalid_d = 1'b1;
          state_d = StRecv;
          count_d = '0;
          hcrc_d = '0;
          dcrc_d = '0;
          dgood_d = 1'b0;
          idx_d = '0;
          crc_d = '0;
          rd_ok_d = 1'b0;
          addr_d = rmap_pkg::MemAddrBits'({hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]});
          if (reject) begin
            oword_d.outcome = rmap_pkg::OutcomeReject;
          end else if (hcrc_q != hdr_q[15]) begin
            oword_d.outcome = rmap_pkg::OutcomeCrc;
          end else if (dl > 24'(rmap_pkg::MaxDataLen)) begin
            oword_d.outcome = rmap_pkg::OutcomeLength;
          end else if (ins[rmap_pkg::BitWrite]) begin
            if (24'(count_q) < 24'd17 + dl) begin
              oword_d.outcome = rmap_pkg::OutcomeLength;
            end else if (!dgood_q) begin
              oword_d.outcome = rmap_pkg::OutcomeCrc;
            end else begin
              ovalid_d = 1'b0;
              state_d = StWrite;
            end
          end else begin
            ovalid_d = 1'b0;
            state_d = StOut;
          end
        end
      end
      StWrite: begin
        if (rd_ok_q) addr_d = addr_q + rmap_pkg::MemAddrBits'(1);
        if (24'(idx_q) < dl) begin
          idx_d = idx_q + 6'd1;
          rd_ok_d = 1'b1;
        end else begin
          rd_ok_d = 1'b0;
          idx_d = '0;
          crc_d = '0;
          if (ins[rmap_pkg::BitReply]) begin
            state_d = StOut;
          end else begin
            oword_d = '{rmap_pkg::ZeroByte, 1'b0, rmap_pkg::OutcomeOk, 1'b1};
            ovalid_d = 1'b1;
            state_d = StRecv;
          end
        end
      end
      StOut: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (idx_q < rep_len) begin
            oword_d = '{rep[idx_q[3:0]], 1'b1, rmap_pkg::OutcomeOk, 1'b0};
            crc_d = rmap_pkg::crc_step(crc_q, rep[idx_q[3:0]]);
            idx_d = idx_q + 6'd1;
          end else begin
            oword_d = '{crc_q, 1'b1, rmap_pkg::OutcomeOk, ins[rmap_pkg::BitWrite]};
            crc_d = '0;
            idx_d = '0;
            rd_ok_d = 1'b0;
            state_d = ins[rmap_pkg::BitWrite] ? StRecv : StRead;
          end
        end
      end
      StRead: begin
        // rd_q is valid in the cycle after addr_q is set; rd_ok_q tracks that.
        if (!rd_ok_q) begin
          rd_ok_d = 1'b1;
        end else if (out_free) begin
          ovalid_d = 1'b1;
          if (24'(idx_q) < dl) begin
            oword_d = '{rd_q, 1'b1, rmap_pkg::OutcomeOk, 1'b0};
            crc_d = rmap_pkg::crc_step(crc_q, rd_q);
            idx_d = idx_q + 6'd1;
            addr_d = addr_q + rmap_pkg::MemAddrBits'(1);
            rd_ok_d = 1'b0;
          end else begin
            oword_d = '{crc_q, 1'b1, rmap_pkg::OutcomeOk, 1'b1};
            state_d = StRecv;
          end
        end
      end
      default: state_d = StRecv;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      enable_q <= 1'b0;
      state_q <= StRecv;
      count_q <= '0;
      hcrc_q <= '0;
      dcrc_q <= '0;
      dgood_q <= 1'b0;
      ovalid_q <= 1'b0;
      oword_q <= '0;
      idx_q <= '0;
      crc_q <= '0;
      addr_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == rmap_pkg::CfgKey) key_q <= cfg_data_i;
        else enable_q <= cfg_data_i[0];
      end
      state_q <= state_d;
      count_q <= count_d;
      hcrc_q <= hcrc_d;
      dcrc_q <= dcrc_d;
      dgood_q <= dgood_d;
      ovalid_q <= ovalid_d;
      oword_q <= oword_d;
      idx_q <= idx_d;
      crc_q <= crc_d;
      addr_q <= addr_d;
      rd_ok_q <= rd_ok_d;
    end
  end

endmodule

// ===== hw/rtl/rmap_checker.sv =====
// Port checker for the RMAP target command engine and its bind statement.
module rmap_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rmap_pkg::out_word_t out_data
);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && !out_ready |=> out_valid && $stable(out_data);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("reply word changed while stalled");

  property p_status_last;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && !out_data.byte_valid |-> out_data.run_last && out_data.reply_byte == 8'd0;
  endproperty
  a_status_last: assert property (p_status_last) else $error("status word malformed");

  property p_err_last;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && out_data.outcome != rmap_pkg::OutcomeOk |-> !out_data.byte_valid;
  endproperty
  a_err_last: assert property (p_err_last) else $error("error outcome on reply byte");

  property p_no_in_while_reply;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && out_data.byte_valid && !out_data.run_last |-> !in_ready;
  endproperty
  a_no_in: assert property (p_no_in_while_reply) else $error("input taken mid reply");

endmodule

bind rmap_target_command_engine rmap_checker u_rmap_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

// ===== verif/rmap_target_command_engine_tb.sv =====
// Testbench for the RMAP target command engine: directed command packets checked word by word.
module rmap_target_command_engine_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;

  rmap_stream_if #(.word_t(rmap_pkg::in_word_t)) in_if ();
  rmap_stream_if #(.word_t(rmap_pkg::out_word_t)) out_if ();

  rmap_target_command_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  // Predictor state.
  logic [7:0] key_q, enable_q, count_q, hcrc_q, dcrc_q;
  logic       dgood_q;
  logic [7:0] hdr_q [16];
  logic [7:0] wbuf_q [rmap_pkg::MaxDataLen];
  logic [7:0] mem_q [rmap_pkg::MemDepth];
  rmap_pkg::out_word_t reply_q [$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;

  function automatic logic [7:0] crc8(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) v = v[0] ? ((v >> 1) ^ 8'hE0) : (v >> 1);
    return v;
  endfunction

  function automatic rmap_pkg::out_word_t mk(input logic [7:0] b, input logic v,
                                             input rmap_pkg::outcome_e o, input logic l);
    rmap_pkg::out_word_t w;
    w.reply_byte = b; w.byte_valid = v; w.outcome = o; w.run_last = l;
    return w;
  endfunction

  task automatic push_status(input rmap_pkg::outcome_e o);
    reply_q.push_back(mk(8'd0, 1'b0, o, 1'b1));
  endtask

  task automatic finish_packet();
    logic [7:0] ins, c;
    logic [7:0] rep [12];
    logic [23:0] dl;
    logic [31:0] addr;
    ins = hdr_q[2];
    dl = {hdr_q[12], hdr_q[13], hdr_q[14]};
    addr = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
    if (count_q < 16) begin
      push_status(rmap_pkg::OutcomeLength); return;
    end
    if (enable_q == 0 || hdr_q[1] != rmap_pkg::ProtoId || hdr_q[3] != key_q
        || !ins[rmap_pkg::BitCmd]) begin
      push_status(rmap_pkg::OutcomeReject); return;
    end
    if (hcrc_q != hdr_q[15]) begin
      push_status(rmap_pkg::OutcomeCrc); return;
    end
    if (dl > rmap_pkg::MaxDataLen) begin
      push_status(rmap_pkg::OutcomeLength); return;
    end
    rep[0] = hdr_q[4]; rep[1] = rmap_pkg::ProtoId;
    rep[2] = ins & ~(8'd1 << rmap_pkg::BitCmd);
    rep[3] = rmap_pkg::ZeroByte; rep[4] = hdr_q[0]; rep[5] = hdr_q[5]; rep[6] = hdr_q[6];
    if (ins[rmap_pkg::BitWrite]) begin
      if (32'(count_q) < 17 + dl) begin
        push_status(rmap_pkg::OutcomeLength); return;
      end
      if (!dgood_q) begin
        push_status(rmap_pkg::OutcomeCrc); return;
      end
      for (int i = 0; i < dl; i++) mem_q[16'(addr + i)] = wbuf_q[i];
      if (!ins[rmap_pkg::BitReply]) begin
        push_status(rmap_pkg::OutcomeOk); return;
      end
      c = 0;
      for (int k = 0; k < 7; k++) c = crc8(c, rep[k]);
      rep[7] = c;
      for (int k = 0; k < 8; k++) begin
        reply_q.push_back(mk(rep[k], 1'b1, rmap_pkg::OutcomeOk, k == 7));
      end
      return;
    end
    rep[7] = rmap_pkg::ZeroByte; rep[8] = hdr_q[12]; rep[9] = hdr_q[13];
    rep[10] = hdr_q[14];
    c = 0;
    for (int k = 0; k < 11; k++) c = crc8(c, rep[k]);
    rep[11] = c;
    for (int k = 0; k < 12; k++) reply_q.push_back(mk(rep[k], 1'b1, rmap_pkg::OutcomeOk, 1'b0));
    c = 0;
    for (int i = 0; i < dl; i++) begin
      c = crc8(c, mem_q[16'(addr + i)]);
      reply_q.push_back(mk(mem_q[16'(addr + i)], 1'b1, rmap_pkg::OutcomeOk, 1'b0));
    end
    reply_q.push_back(mk(c, 1'b1, rmap_pkg::OutcomeOk, 1'b1));
  endtask

  task automatic predict(input logic [7:0] b, input logic e);
    logic [7:0] d;
    logic [23:0] dl;
    if (count_q < 16) begin
      hdr_q[count_q[3:0]] = b;
      if (count_q < 15) hcrc_q = crc8(hcrc_q, b);
    end else begin
      d = count_q - 8'd16;
      dl = {hdr_q[12], hdr_q[13], hdr_q[14]};
      if (d < rmap_pkg::MaxDataLen) wbuf_q[d[rmap_pkg::BufAddrBits-1:0]] = b;
      if (24'(d) < dl) dcrc_q = crc8(dcrc_q, b);
      else if (24'(d) == dl) dgood_q = (b == dcrc_q);
    end
    if (count_q < 255) count_q++;
    if (e) begin
      finish_packet();
      count_q = 0; hcrc_q = 0; dcrc_q = 0; dgood_q = 0;
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic e);
    while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{packet_byte: b, packet_end: e};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict(b, e);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (reply_q.size() > 0 && guard < 200000) begin
      @(posedge clk_i); guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rmap_pkg::CfgKey) key_q = val; else enable_q = {7'd0, val[0]};
  endtask

  task automatic send_command(input logic wr, input logic rep, input logic [31:0] addr,
                              input logic [23:0] len, input logic bad_hcrc,
                              input logic bad_dcrc, input int trunc);
    logic [7:0] h [16];
    logic [7:0] c, b;
    int total;
    h[0] = 8'($urandom); h[1] = rmap_pkg::ProtoId;
    h[2] = 8'($urandom) | (8'd1 << rmap_pkg::BitCmd);
    h[2][rmap_pkg::BitWrite] = wr; h[2][rmap_pkg::BitReply] = rep; h[2][7] = 1'($urandom);
    h[3] = key_q; h[4] = 8'($urandom); h[5] = 8'($urandom); h[6] = 8'($urandom);
    h[7] = 8'($urandom);
    {h[8], h[9], h[10], h[11]} = addr;
    {h[12], h[13], h[14]} = len;
    c = 0;
    for (int k = 0; k < 15; k++) c = crc8(c, h[k]);
    h[15] = bad_hcrc ? ~c : c;
    total = wr ? 17 + int'(len) : 16;
    if (trunc > 0) total = trunc;
    c = 0;
    for (int k = 0; k < total; k++) begin
      if (k < 16) b = h[k];
      else if (k - 16 < len) begin
        b = 8'($urandom); c = crc8(c, b);
      end else b = bad_dcrc ? ~c : c;
      send_word(b, k == total - 1);
    end
  endtask

  task automatic test_short_packets();
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_disabled();
    send_command(1'b0, 1'b1, 32'h0000_0010, 24'd1, 1'b0, 1'b0, 0);
  endtask

  task automatic test_write_wrap();
    send_command(1'b1, 1'b1, 32'h0001_FFFF, 24'd2, 1'b0, 1'b0, 0);
  endtask

  task automatic test_read_wrap();
    send_command(1'b0, 1'b1, 32'h0000_FFFF, 24'd2, 1'b0, 1'b0, 0);
  endtask

  task automatic test_read_empty();
    send_command(1'b0, 1'b0, 32'h0000_0020, 24'd0, 1'b0, 1'b0, 0);
  endtask

  task automatic test_write_silent();
    send_command(1'b1, 1'b0, 32'h0000_0040, 24'd0, 1'b0, 1'b0, 0);
  endtask

  task automatic test_header_crc();
    send_command(1'b0, 1'b1, 32'h0000_FFFF, 24'd1, 1'b1, 1'b0, 0);
  endtask

  task automatic test_short_write();
    send_command(1'b1, 1'b1, 32'h0000_0080, 24'd2, 1'b0, 1'b0, 16);
  endtask

  initial begin : check_replies
    rmap_pkg::out_word_t exp_w;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", out_if.data);
        end else begin
          exp_w = reply_q.pop_front();
          if (out_if.data !== exp_w) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h actual %h", exp_w, out_if.data);
          end
        end
      end
    end
  end

  initial begin : drive_ready
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= !(recv_idle > 0 && $urandom_range(99, 0) < recv_idle);
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    key_q = 0; enable_q = 0; count_q = 0; hcrc_q = 0; dcrc_q = 0; dgood_q = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 20; recv_idle = 56;
    test_short_packets();
    test_disabled();
    write_cfg(rmap_pkg::CfgKey, 8'h5A);
    write_cfg(rmap_pkg::CfgEnable, 8'h01);
    test_write_wrap();
    drain();
    send_idle = 56; recv_idle = 20;
    test_read_wrap();
    test_read_empty();
    test_write_silent();
    drain();
    send_idle = 0; recv_idle = 0;
    test_header_crc();
    test_short_write();
    drain();
    if (reply_q.size() != 0) errors++;
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
